// ===== src/rsc_pkg.sv =====
`default_nettype none

package rsc_pkg;

    // Fixed field widths
    localparam int CFG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_CLASSES    = 4;
    localparam int CLS_IDX_BITS   = 2;
    localparam int CLASS_BITS     = 3;
    localparam int STEP_BITS      = 11;
    localparam int TRAY_BITS      = 11;
    localparam int PHASE_BITS     = 2;
    localparam int COIL_BITS      = 4;
    localparam int TOTAL_BITS     = 16;

    // One revolution of the tray; tray arithmetic wraps in TRAY_BITS
    localparam int STEPS_PER_REV = 2048;

    localparam logic [TRAY_BITS-1:0] TRAY_THREE_QUARTER = TRAY_BITS'(STEPS_PER_REV * 3 / 4);
    localparam logic [TRAY_BITS-1:0] TRAY_QUARTER       = TRAY_BITS'(STEPS_PER_REV / 4);
    localparam logic [TRAY_BITS-1:0] TRAY_HALF          = TRAY_BITS'(STEPS_PER_REV / 2);
    localparam logic [TRAY_BITS-1:0] TRAY_HOME          = '0;

    localparam logic [STEP_BITS-1:0] MOVE_NONE    = '0;
    localparam logic [STEP_BITS-1:0] MOVE_ONE     = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] MOVE_QUARTER = STEP_BITS'(STEPS_PER_REV / 4);
    localparam logic [STEP_BITS-1:0] MOVE_HALF    = STEP_BITS'(STEPS_PER_REV / 2);

    localparam logic [COIL_BITS-1:0] COIL_PHASE_ONE = 4'b1000;

    // Material classes
    localparam logic [CLASS_BITS-1:0] CLS_NONE = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLS_ONE  = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLS_TWO  = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLS_THREE = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLS_FOUR = 3'd4;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_EXIT   = 2'd2,
        OP_HOME   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_CLASS = 2'd1,
        KIND_SORT  = 2'd2,
        KIND_HOME  = 2'd3
    } kind_t;

    typedef logic [NUM_CLASSES-1:0][CFG_BITS-1:0] thr_set_t;

    typedef struct packed {
        logic                 ccw;
        logic [STEP_BITS-1:0] steps;
    } move_t;

endpackage

`default_nettype wire

// ===== src/reflectance_sorter_controller_core.sv =====
`default_nettype none

// Channel   Signals                                      Direction  Moves
// --------  -------------------------------------------  ---------  -----------------------
// in        in_valid/in_ready, op, sample,               sink       one conveyor request
//           sensor_still_high, hall_clear
// out       out_valid/out_ready, kind, material_class,   source     one result per request
//           move_ccw, move_steps, coil_pattern, tray_position,
//           queue_count, class_total, queue_*_error
// cfg       cfg_we, cfg_index, cfg_data                  sink       threshold write, no wait
//
// One request per cycle sustained while the output is not stalled.
// Stage 1 holds the request; all state (minimum, FIFO, tray, coils, counters)
// updates as it moves into the result register.
// The FIFO head entry is kept in a register, reread as each request retires with
// bypass of a same-cycle push, so a pop never waits on the memory port.
// A stalled output holds stage 1; in_ready drops only when both are full.
// Reset clears control and state; FIFO contents are undefined until written.

module reflectance_sorter_controller_core #(
    parameter int FIFO_DEPTH  = 64,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic                                sensor_still_high,
    input  logic                                hall_clear,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          kind,
    output logic [rsc_pkg::CLASS_BITS-1:0]      material_class,
    output logic                                move_ccw,
    output logic [rsc_pkg::STEP_BITS-1:0]       move_steps,
    output logic [rsc_pkg::COIL_BITS-1:0]       coil_pattern,
    output logic [rsc_pkg::TRAY_BITS-1:0]       tray_position,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     queue_count,
    output logic [rsc_pkg::TOTAL_BITS-1:0]      class_total,
    output logic                                queue_empty_error,
    output logic                                queue_full_error,

    input  logic                                cfg_we,
    input  logic [rsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rsc_pkg::CFG_BITS-1:0]        cfg_data
);
    import rsc_pkg::*;

    localparam int MIN_BITS = SAMPLE_BITS + 1;
    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [MIN_BITS-1:0] MIN_START = MIN_BITS'(1) << SAMPLE_BITS;
    localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(FIFO_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(FIFO_DEPTH);

    // ---------------- thresholds ----------------
    thr_set_t thr_lo_reg;
    thr_set_t thr_hi_reg;

    // even index = low bound, odd index = high bound, upper bits pick the class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_lo_reg <= '0;
            thr_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index[0])
            begin
                thr_hi_reg[cfg_index[CFG_INDEX_BITS-1:1]] <= cfg_data;
            end
            else
            begin
                thr_lo_reg[cfg_index[CFG_INDEX_BITS-1:1]] <= cfg_data;
            end
        end
    end

    // ---------------- stage 1: request register ----------------
    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_still_reg;
    logic                   s1_hall_reg;
    logic                   s1_go;
    logic                   out_valid_reg;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg     <= op_t'(op);
            s1_sample_reg <= sample;
            s1_still_reg  <= sensor_still_high;
            s1_hall_reg   <= hall_clear;
        end
    end

    // ---------------- controller state ----------------
    logic [MIN_BITS-1:0]                     min_reg,   min_next;
    logic [PTR_BITS-1:0]                     head_reg,  head_next;
    logic [PTR_BITS-1:0]                     tail_reg,  tail_next;
    logic [CNT_BITS-1:0]                     count_reg, count_next;
    logic [TRAY_BITS-1:0]                    tray_reg,  tray_next;
    logic [PHASE_BITS-1:0]                   phase_reg, phase_next;
    logic [NUM_CLASSES-1:0][TOTAL_BITS-1:0]  total_reg, total_next;
    logic [CLASS_BITS-1:0]                   head_data_reg;
    logic [CLASS_BITS-1:0]                   piece_fifo_reg [FIFO_DEPTH];

    logic [CLASS_BITS-1:0]   new_class;
    logic [CLASS_BITS-1:0]   cls;
    logic                    classify_evt;
    logic                    push;
    logic                    pop;
    logic                    err_full;
    logic                    err_empty;
    logic                    do_home;
    logic                    counted;
    logic [CLS_IDX_BITS-1:0] cnt_idx;
    logic [TOTAL_BITS-1:0]   total;
    kind_t                   kind_val;
    move_t                   move;

    // sample lowers the minimum before it is classified
    always_comb
    begin
        min_next = min_reg;
        case (s1_op_reg)
            OP_START:
            begin
                min_next = MIN_START;
            end
            OP_SAMPLE:
            begin
                if (MIN_BITS'(s1_sample_reg) < min_reg)
                begin
                    min_next = MIN_BITS'(s1_sample_reg);
                end
            end
            default:
            begin
                min_next = min_reg;
            end
        endcase
    end

    rsc_classify #(
        .VAL_BITS (MIN_BITS)
    ) u_classify (
        .value          (min_next),
        .thr_lo         (thr_lo_reg),
        .thr_hi         (thr_hi_reg),
        .material_class (new_class)
    );

    always_comb
    begin
        classify_evt = (s1_op_reg == OP_SAMPLE) && !s1_still_reg;
        push         = classify_evt && (count_reg != CNT_FULL);
        err_full     = classify_evt && (count_reg == CNT_FULL);
        pop          = (s1_op_reg == OP_EXIT) && (count_reg != '0);
        err_empty    = (s1_op_reg == OP_EXIT) && (count_reg == '0);
        do_home      = (s1_op_reg == OP_HOME);

        case (s1_op_reg)
            OP_SAMPLE: kind_val = classify_evt ? KIND_CLASS : KIND_ACK;
            OP_EXIT:   kind_val = KIND_SORT;
            OP_HOME:   kind_val = KIND_HOME;
            default:   kind_val = KIND_ACK;
        endcase

        if (classify_evt)
        begin
            cls = new_class;
        end
        else if (pop)
        begin
            cls = head_data_reg;
        end
        else
        begin
            cls = CLS_NONE;
        end

        tail_next = push ? ((tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1) : tail_reg;
        head_next = pop  ? ((head_reg == PTR_LAST) ? '0 : head_reg + 1'b1) : head_reg;

        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // per-class saturating counters
    always_comb
    begin
        counted    = pop && (cls inside {[CLS_ONE:CLS_FOUR]});
        cnt_idx    = CLS_IDX_BITS'(cls - CLS_ONE);
        total_next = total_reg;
        total      = '0;
        if (counted)
        begin
            if (total_reg[cnt_idx] != '1)
            begin
                total_next[cnt_idx] = total_reg[cnt_idx] + 1'b1;
            end
            total = total_next[cnt_idx];
        end
    end

    rsc_tray u_tray (
        .tray           (tray_reg),
        .phase          (phase_reg),
        .material_class (cls),
        .do_sort        (pop),
        .do_home        (do_home),
        .hall_clear     (s1_hall_reg),
        .tray_next      (tray_next),
        .phase_next     (phase_next),
        .move           (move)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= MIN_START;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            tray_reg  <= '0;
            phase_reg <= '0;
            total_reg <= '0;
        end
        else if (s1_go)
        begin
            min_reg   <= min_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            tray_reg  <= tray_next;
            phase_reg <= phase_next;
            total_reg <= total_next;
        end
    end

    // FIFO memory: one write, one registered read of the next head entry
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            if (push)
            begin
                piece_fifo_reg[tail_reg] <= new_class;
            end
            if (push && (tail_reg == head_next))
            begin
                head_data_reg <= new_class;
            end
            else
            begin
                head_data_reg <= piece_fifo_reg[head_next];
            end
        end
    end

    // ---------------- result register ----------------
    logic [1:0]            kind_reg;
    logic [CLASS_BITS-1:0] class_reg;
    logic                  ccw_reg;
    logic [STEP_BITS-1:0]  steps_reg;
    logic [COIL_BITS-1:0]  coil_reg;
    logic [TRAY_BITS-1:0]  tray_out_reg;
    logic [CNT_BITS-1:0]   count_out_reg;
    logic [TOTAL_BITS-1:0] total_out_reg;
    logic                  err_empty_reg;
    logic                  err_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            kind_reg      <= kind_val;
            class_reg     <= cls;
            ccw_reg       <= move.ccw;
            steps_reg     <= move.steps;
            coil_reg      <= COIL_PHASE_ONE >> phase_next;
            tray_out_reg  <= tray_next;
            count_out_reg <= count_next;
            total_out_reg <= total;
            err_empty_reg <= err_empty;
            err_full_reg  <= err_full;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign material_class    = class_reg;
    assign move_ccw          = ccw_reg;
    assign move_steps        = steps_reg;
    assign coil_pattern      = coil_reg;
    assign tray_position     = tray_out_reg;
    assign queue_count       = count_out_reg;
    assign class_total       = total_out_reg;
    assign queue_empty_error = err_empty_reg;
    assign queue_full_error  = err_full_reg;

endmodule

`default_nettype wire

// ===== src/rsc_classify.sv =====
`default_nettype none

module rsc_classify #(
    parameter int VAL_BITS = 11
) (
    input  logic [VAL_BITS-1:0]            value,
    input  rsc_pkg::thr_set_t              thr_lo,
    input  rsc_pkg::thr_set_t              thr_hi,
    output logic [rsc_pkg::CLASS_BITS-1:0] material_class
);
    import rsc_pkg::*;

    localparam int CMP_BITS = (VAL_BITS > CFG_BITS) ? VAL_BITS : CFG_BITS;

    logic [NUM_CLASSES-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            hit[k] = (CMP_BITS'(thr_lo[k]) <= CMP_BITS'(value)) &&
                     (CMP_BITS'(value) <= CMP_BITS'(thr_hi[k]));
        end
    end

    // first matching range wins
    always_comb
    begin
        if (hit[0])
        begin
            material_class = CLS_ONE;
        end
        else if (hit[1])
        begin
            material_class = CLS_TWO;
        end
        else if (hit[2])
        begin
            material_class = CLS_THREE;
        end
        else if (hit[3])
        begin
            material_class = CLS_FOUR;
        end
        else
        begin
            material_class = CLS_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== src/rsc_tray.sv =====
`default_nettype none

module rsc_tray (
    input  logic [rsc_pkg::TRAY_BITS-1:0]  tray,
    input  logic [rsc_pkg::PHASE_BITS-1:0] phase,
    input  logic [rsc_pkg::CLASS_BITS-1:0] material_class,
    input  logic                           do_sort,
    input  logic                           do_home,
    input  logic                           hall_clear,
    output logic [rsc_pkg::TRAY_BITS-1:0]  tray_next,
    output logic [rsc_pkg::PHASE_BITS-1:0] phase_next,
    output rsc_pkg::move_t                 move
);
    import rsc_pkg::*;

    logic [TRAY_BITS-1:0] target;
    logic [TRAY_BITS-1:0] tray_gap;

    always_comb
    begin
        case (material_class)
            CLS_ONE:   target = TRAY_THREE_QUARTER;
            CLS_TWO:   target = TRAY_QUARTER;
            CLS_THREE: target = TRAY_HALF;
            default:   target = TRAY_HOME;
        endcase
    end

    // distance modulo one revolution
    assign tray_gap = target - tray;

    always_comb
    begin
        move.ccw   = 1'b0;
        move.steps = MOVE_NONE;
        if (do_sort)
        begin
            if (tray_gap == TRAY_THREE_QUARTER)
            begin
                move.ccw   = 1'b1;
                move.steps = MOVE_QUARTER;
            end
            else if (tray_gap == TRAY_QUARTER)
            begin
                move.steps = MOVE_QUARTER;
            end
            else if (tray_gap == TRAY_HALF)
            begin
                move.steps = MOVE_HALF;
            end
        end
        else if (do_home && hall_clear)
        begin
            move.steps = MOVE_ONE;
        end
    end

    always_comb
    begin
        if (move.ccw)
        begin
            tray_next  = tray - TRAY_BITS'(move.steps);
            phase_next = phase - move.steps[PHASE_BITS-1:0];
        end
        else
        begin
            tray_next  = tray + TRAY_BITS'(move.steps);
            phase_next = phase + move.steps[PHASE_BITS-1:0];
        end
        if (do_home && !hall_clear)
        begin
            tray_next = TRAY_HOME;
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    // DUT build and bench limits
    localparam int DEPTH          = 64;
    localparam int SAMPLE_W       = 10;
    localparam int COUNT_W        = $clog2(DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no request or result moving
    localparam int DRAIN_CYCLES   = 16;     // wait before the final check for results that never arrived
    localparam int PHASE_ITEMS    = 220;
    localparam int REPORT_LIMIT   = 10;

    // Tray distances that produce a move
    localparam int QUARTER_REV       = STEPS_PER_REV / 4;
    localparam int HALF_REV          = STEPS_PER_REV / 2;
    localparam int THREE_QUARTER_REV = STEPS_PER_REV * 3 / 4;

    // Threshold register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CLASS1_LOW  = 3'd0,
        REG_CLASS1_HIGH = 3'd1,
        REG_CLASS2_LOW  = 3'd2,
        REG_CLASS2_HIGH = 3'd3,
        REG_CLASS3_LOW  = 3'd4,
        REG_CLASS3_HIGH = 3'd5,
        REG_CLASS4_LOW  = 3'd6,
        REG_CLASS4_HIGH = 3'd7
    } thr_reg_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CLASS_BITS-1:0] cls;
        logic                  ccw;
        logic [STEP_BITS-1:0]  steps;
        logic [COIL_BITS-1:0]  coil;
        logic [TRAY_BITS-1:0]  tray;
        logic [COUNT_W-1:0]    count;
        logic [TOTAL_BITS-1:0] total;
        logic                  empty_err;
        logic                  full_err;
    } sorter_result_t;

    // One conveyor request; has_want marks a row whose result is typed in
    typedef struct packed {
        op_t                   op;
        logic [SAMPLE_W-1:0]   sample;
        logic                  still;
        logic                  hall;
        logic                  has_want;
        sorter_result_t        want;
    } conveyor_req_t;

    // Directed table, run with all thresholds at reset (class one matches 0 only)
    localparam int DIRECTED_ROWS = 24;
    localparam conveyor_req_t DIRECTED [DIRECTED_ROWS] = '{
        // op        sample st  hall typed  kind      cls ccw steps coil tray cnt tot emp ful
        '{OP_START,  0,     0,  0,   1, '{KIND_ACK,   0,  0,  0,    8,   0,    0,  0,  0,  0}},
        // pop with nothing waiting
        '{OP_EXIT,   0,     0,  0,   1, '{KIND_SORT,  0,  0,  0,    8,   0,    0,  0,  1,  0}},
        // already home
        '{OP_HOME,   0,     0,  0,   1, '{KIND_HOME,  0,  0,  0,    8,   0,    0,  0,  0,  0}},
        // single steps walk the coil through all four phases and wrap
        '{OP_HOME,   0,     0,  1,   1, '{KIND_HOME,  0,  0,  1,    4,   1,    0,  0,  0,  0}},
        '{OP_HOME,   1023,  1,  1,   1, '{KIND_HOME,  0,  0,  1,    2,   2,    0,  0,  0,  0}},
        '{OP_HOME,   0,     1,  1,   1, '{KIND_HOME,  0,  0,  1,    1,   3,    0,  0,  0,  0}},
        '{OP_HOME,   1023,  0,  1,   1, '{KIND_HOME,  0,  0,  1,    8,   4,    0,  0,  0,  0}},
        '{OP_HOME,   0,     0,  1,   1, '{KIND_HOME,  0,  0,  1,    4,   5,    0,  0,  0,  0}},
        // hall trips: position zeroed, coil phase left where it is
        '{OP_HOME,   1023,  1,  0,   1, '{KIND_HOME,  0,  0,  0,    4,   0,    0,  0,  0,  0}},
        '{OP_START,  1023,  1,  1,   1, '{KIND_ACK,   0,  0,  0,    4,   0,    0,  0,  0,  0}},
        '{OP_SAMPLE, 1023,  1,  0,   1, '{KIND_ACK,   0,  0,  0,    4,   0,    0,  0,  0,  0}},
        '{OP_SAMPLE, 0,     0,  1,   1, '{KIND_CLASS, 1,  0,  0,    4,   0,    1,  0,  0,  0}},
        '{OP_START,  0,     0,  0,   1, '{KIND_ACK,   0,  0,  0,    4,   0,    1,  0,  0,  0}},
        // unmatched minimum is still queued
        '{OP_SAMPLE, 1023,  0,  0,   1, '{KIND_CLASS, 0,  0,  0,    4,   0,    2,  0,  0,  0}},
        // class one from home: ccw quarter turn
        '{OP_EXIT,   0,     1,  1,   1, '{KIND_SORT,  1,  1,  512,  4,   1536, 1,  1,  0,  0}},
        // unmatched class goes to home, cw quarter turn, no counter
        '{OP_EXIT,   1023,  0,  0,   1, '{KIND_SORT,  0,  0,  512,  4,   0,    0,  0,  0,  0}},
        // no piece start: minimum carries over
        '{OP_SAMPLE, 512,   1,  0,   0, '0},
        '{OP_SAMPLE, 700,   0,  1,   0, '0},
        // already at the target
        '{OP_EXIT,   5,     0,  0,   0, '0},
        '{OP_HOME,   0,     0,  1,   0, '0},
        '{OP_EXIT,   0,     0,  0,   0, '0},
        '{OP_SAMPLE, 0,     0,  0,   0, '0},
        // distance off the quarter grid: no move
        '{OP_EXIT,   1023,  1,  1,   0, '0},
        '{OP_START,  1023,  1,  1,   0, '0}
    };

    // DUT connections; every input is known from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid          = 1'b0;
    logic                  in_ready;
    op_t                   op                = OP_START;
    logic [SAMPLE_W-1:0]   sample            = '0;
    logic                  sensor_still_high = 1'b0;
    logic                  hall_clear        = 1'b0;

    logic                  out_valid;
    logic                  out_ready         = 1'b0;
    logic [1:0]            kind;
    logic [CLASS_BITS-1:0] material_class;
    logic                  move_ccw;
    logic [STEP_BITS-1:0]  move_steps;
    logic [COIL_BITS-1:0]  coil_pattern;
    logic [TRAY_BITS-1:0]  tray_position;
    logic [COUNT_W-1:0]    queue_count;
    logic [TOTAL_BITS-1:0] class_total;
    logic                  queue_empty_error;
    logic                  queue_full_error;

    logic                  cfg_we            = 1'b0;
    thr_reg_t              cfg_index         = REG_CLASS1_LOW;
    logic [CFG_BITS-1:0]   cfg_data          = '0;

    reflectance_sorter_controller_core #(
        .FIFO_DEPTH  (DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .sample            (sample),
        .sensor_still_high (sensor_still_high),
        .hall_clear        (hall_clear),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .material_class    (material_class),
        .move_ccw          (move_ccw),
        .move_steps        (move_steps),
        .coil_pattern      (coil_pattern),
        .tray_position     (tray_position),
        .queue_count       (queue_count),
        .class_total       (class_total),
        .queue_empty_error (queue_empty_error),
        .queue_full_error  (queue_full_error),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the sorter state
    logic [SAMPLE_W:0]        min_seen;
    logic [CLASS_BITS-1:0]    class_fifo [DEPTH];
    int                       fifo_rd;
    int                       fifo_wr;
    int                       fifo_fill;
    logic [TRAY_BITS-1:0]     tray_at;
    logic [PHASE_BITS-1:0]    phase_at;
    logic [TOTAL_BITS-1:0]    sorted_count [NUM_CLASSES];
    logic [NUM_CLASSES-1:0][CFG_BITS-1:0] thr_low;
    logic [NUM_CLASSES-1:0][CFG_BITS-1:0] thr_high;

    // Requests waiting to be offered, results waiting to arrive
    conveyor_req_t  conveyor_plan [$];
    sorter_result_t pending_results [$];

    // Idle chance per cycle, in percent
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    conveyor_req_t  cur_req;
    sorter_result_t got_res;
    sorter_result_t want_res;
    int             quiet_cycles = 0;
    int             failures     = 0;
    int             results_seen = 0;

    // First matching range wins, ranges checked in class order
    function automatic logic [CLASS_BITS-1:0] match_class(logic [SAMPLE_W:0] v);
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (thr_low[k] <= v && v <= thr_high[k])
                return CLASS_BITS'(k + 1);
        end
        return CLS_NONE;
    endfunction

    // Advances the shadow state by one request and returns its result
    function automatic sorter_result_t sorter_predict(conveyor_req_t r);
        sorter_result_t       res;
        logic [TRAY_BITS-1:0] target;
        int                   diff;
        res      = '0;
        res.kind = KIND_ACK;
        case (r.op)
            OP_START:
            begin
                min_seen = (SAMPLE_W + 1)'(1) << SAMPLE_W;
            end
            OP_SAMPLE:
            begin
                if ({1'b0, r.sample} < min_seen)
                    min_seen = {1'b0, r.sample};
                if (!r.still)
                begin
                    res.kind = KIND_CLASS;
                    res.cls  = match_class(min_seen);
                    if (fifo_fill >= DEPTH)
                        res.full_err = 1'b1;
                    else
                    begin
                        class_fifo[fifo_wr] = res.cls;
                        fifo_wr   = (fifo_wr == DEPTH - 1) ? 0 : fifo_wr + 1;
                        fifo_fill = fifo_fill + 1;
                    end
                end
            end
            OP_EXIT:
            begin
                res.kind = KIND_SORT;
                if (fifo_fill == 0)
                    res.empty_err = 1'b1;
                else
                begin
                    res.cls   = class_fifo[fifo_rd];
                    fifo_rd   = (fifo_rd == DEPTH - 1) ? 0 : fifo_rd + 1;
                    fifo_fill = fifo_fill - 1;
                    case (res.cls)
                        CLS_ONE:   target = TRAY_THREE_QUARTER;
                        CLS_TWO:   target = TRAY_QUARTER;
                        CLS_THREE: target = TRAY_HALF;
                        default:   target = TRAY_HOME;
                    endcase
                    if (res.cls >= CLS_ONE && res.cls <= CLS_FOUR)
                    begin
                        if (sorted_count[res.cls - 1] != '1)
                            sorted_count[res.cls - 1] = sorted_count[res.cls - 1] + 1'b1;
                        res.total = sorted_count[res.cls - 1];
                    end
                    diff = int'(target) - int'(tray_at);
                    if (diff == -QUARTER_REV || diff == THREE_QUARTER_REV)
                    begin
                        res.ccw   = 1'b1;
                        res.steps = MOVE_QUARTER;
                    end
                    else if (diff == QUARTER_REV || diff == -THREE_QUARTER_REV)
                        res.steps = MOVE_QUARTER;
                    else if (diff == HALF_REV || diff == -HALF_REV)
                        res.steps = MOVE_HALF;
                    // tray and phase wrap naturally in their widths
                    if (res.ccw)
                    begin
                        tray_at  = tray_at - res.steps;
                        phase_at = phase_at - res.steps[PHASE_BITS-1:0];
                    end
                    else
                    begin
                        tray_at  = tray_at + res.steps;
                        phase_at = phase_at + res.steps[PHASE_BITS-1:0];
                    end
                end
            end
            default:
            begin
                res.kind = KIND_HOME;
                if (r.hall)
                begin
                    res.steps = MOVE_ONE;
                    tray_at   = tray_at + 1'b1;
                    phase_at  = phase_at + 1'b1;
                end
                else
                    tray_at = TRAY_HOME;
            end
        endcase
        res.coil  = COIL_PHASE_ONE >> phase_at;
        res.tray  = tray_at;
        res.count = COUNT_W'(fifo_fill);
        return res;
    endfunction

    function automatic string result_text(sorter_result_t r);
        return $sformatf("kind=%0d cls=%0d ccw=%0d steps=%0d coil=%b tray=%0d count=%0d total=%0d empty=%0d full=%0d",
                         r.kind, r.cls, r.ccw, r.steps, r.coil, r.tray, r.count, r.total,
                         r.empty_err, r.full_err);
    endfunction

    task automatic compare_result(sorter_result_t want, sorter_result_t got);
        string bad;
        bad = "";
        if (got.kind      !== want.kind)      bad = {bad, " kind"};
        if (got.cls       !== want.cls)       bad = {bad, " material_class"};
        if (got.ccw       !== want.ccw)       bad = {bad, " move_ccw"};
        if (got.steps     !== want.steps)     bad = {bad, " move_steps"};
        if (got.coil      !== want.coil)      bad = {bad, " coil_pattern"};
        if (got.tray      !== want.tray)      bad = {bad, " tray_position"};
        if (got.count     !== want.count)     bad = {bad, " queue_count"};
        if (got.total     !== want.total)     bad = {bad, " class_total"};
        if (got.empty_err !== want.empty_err) bad = {bad, " queue_empty_error"};
        if (got.full_err  !== want.full_err)  bad = {bad, " queue_full_error"};
        if (bad.len() != 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("result %0d wrong:%s", results_seen, bad);
                $display("  expected %s", result_text(want));
                $display("  actual   %s", result_text(got));
            end
        end
    endtask

    // Both channels and the watchdog, one process so that the result side is
    // always handled before the request side at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;

            if (out_valid && out_ready)
            begin
                quiet_cycles        = 0;
                got_res.kind        = kind_t'(kind);
                got_res.cls         = material_class;
                got_res.ccw         = move_ccw;
                got_res.steps       = move_steps;
                got_res.coil        = coil_pattern;
                got_res.tray        = tray_position;
                got_res.count       = queue_count;
                got_res.total       = class_total;
                got_res.empty_err   = queue_empty_error;
                got_res.full_err    = queue_full_error;
                if (pending_results.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("result with no request pending: %s", result_text(got_res));
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    compare_result(want_res, got_res);
                end
                results_seen++;
            end

            if (in_valid && in_ready)
            begin
                quiet_cycles = 0;
                // predictor always runs so the shadow state tracks typed rows too
                want_res = sorter_predict(cur_req);
                if (cur_req.has_want)
                    want_res = cur_req.want;
                pending_results.push_back(want_res);
            end

            // next request: only when the line is free or was just taken
            if (!in_valid || in_ready)
            begin
                if (conveyor_plan.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req           = conveyor_plan.pop_front();
                    in_valid          <= 1'b1;
                    op                <= cur_req.op;
                    sample            <= cur_req.sample;
                    sensor_still_high <= cur_req.still;
                    hall_clear        <= cur_req.hall;
                end
                else
                    in_valid <= 1'b0;
            end

            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Random request of a given op; unused fields random too
    function automatic conveyor_req_t noisy_req(op_t o);
        conveyor_req_t r;
        r        = '0;
        r.op     = o;
        r.sample = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        r.still  = 1'($urandom_range(0, 1));
        r.hall   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Reflectance with extra weight on both rails
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endfunction

    // One piece: optional start, samples under the sensor, then the clearing sample
    task automatic plan_piece(input bit with_start, input int samples, inout int n);
        conveyor_req_t r;
        if (with_start)
        begin
            conveyor_plan.push_back(noisy_req(OP_START));
            n++;
        end
        repeat (samples)
        begin
            r        = noisy_req(OP_SAMPLE);
            r.sample = pick_sample();
            r.still  = 1'b1;
            conveyor_plan.push_back(r);
            n++;
        end
        r        = noisy_req(OP_SAMPLE);
        r.sample = pick_sample();
        r.still  = 1'b0;
        conveyor_plan.push_back(r);
        n++;
    endtask

    // Overfill the FIFO, then drain it past empty
    task automatic plan_fill_burst(inout int n);
        repeat (DEPTH + 2)
            plan_piece(1'b1, 0, n);
        repeat (DEPTH + 4)
        begin
            conveyor_plan.push_back(noisy_req(OP_EXIT));
            n++;
        end
    endtask

    task automatic plan_traffic(input int budget);
        int            n;
        int            sel;
        conveyor_req_t r;
        n = 0;
        while (n < budget)
        begin
            sel = $urandom_range(0, 199);
            if (sel < 80)
                // a few pieces skip the start and inherit the old minimum
                plan_piece(sel >= 8, $urandom_range(0, 4), n);
            else if (sel < 160)
            begin
                conveyor_plan.push_back(noisy_req(OP_EXIT));
                n++;
            end
            else if (sel < 180)
            begin
                repeat ($urandom_range(0, 5))
                begin
                    r      = noisy_req(OP_HOME);
                    r.hall = 1'b1;
                    conveyor_plan.push_back(r);
                    n++;
                end
                // most homing runs end on the hall sensor
                if ($urandom_range(0, 99) < 85)
                begin
                    r      = noisy_req(OP_HOME);
                    r.hall = 1'b0;
                    conveyor_plan.push_back(r);
                    n++;
                end
            end
            else if (sel < 198)
            begin
                conveyor_plan.push_back(noisy_req(op_t'($urandom_range(0, 3))));
                n++;
            end
            else
                plan_fill_burst(n);
        end
    endtask

    task automatic wait_drained();
        while (conveyor_plan.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input thr_reg_t idx, input logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx[0])
            thr_high[idx[CFG_INDEX_BITS-1:1]] = val;
        else
            thr_low[idx[CFG_INDEX_BITS-1:1]] = val;
    endtask

    task automatic load_thresholds(input logic [NUM_CLASSES-1:0][CFG_BITS-1:0] lo,
                                   input logic [NUM_CLASSES-1:0][CFG_BITS-1:0] hi);
        write_reg(REG_CLASS1_LOW,  lo[0]);
        write_reg(REG_CLASS1_HIGH, hi[0]);
        write_reg(REG_CLASS2_LOW,  lo[1]);
        write_reg(REG_CLASS2_HIGH, hi[1]);
        write_reg(REG_CLASS3_LOW,  lo[2]);
        write_reg(REG_CLASS3_HIGH, hi[2]);
        write_reg(REG_CLASS4_LOW,  lo[3]);
        write_reg(REG_CLASS4_HIGH, hi[3]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [NUM_CLASSES-1:0][CFG_BITS-1:0] lo;
        logic [NUM_CLASSES-1:0][CFG_BITS-1:0] hi;
        int burst_n;

        // shadow state at reset
        min_seen  = (SAMPLE_W + 1)'(1) << SAMPLE_W;
        fifo_rd   = 0;
        fifo_wr   = 0;
        fifo_fill = 0;
        tray_at   = TRAY_HOME;
        phase_at  = '0;
        thr_low   = '0;
        thr_high  = '0;
        foreach (sorted_count[i])
            sorted_count[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table under reset thresholds
        send_idle_pct = 32;
        recv_idle_pct = 77;
        foreach (DIRECTED[i])
            conveyor_plan.push_back(DIRECTED[i]);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            repeat (4) @(negedge clk);
            case (ph)
                0:
                    // every range covers everything: class one always wins
                    for (int k = 0; k < NUM_CLASSES; k++)
                    begin
                        lo[k] = '0;
                        hi[k] = '1;
                    end
                1:
                    // four disjoint quarters
                    for (int k = 0; k < NUM_CLASSES; k++)
                    begin
                        lo[k] = CFG_BITS'(k * 256);
                        hi[k] = CFG_BITS'(k * 256 + 255);
                    end
                3:
                    // top rail only
                    for (int k = 0; k < NUM_CLASSES; k++)
                    begin
                        lo[k] = '1;
                        hi[k] = '1;
                    end
                4:
                begin
                    // overlapping ranges, order decides
                    lo = {10'd0,    10'd500,  10'd0,   10'd300};
                    hi = {10'd1023, 10'd1023, 10'd400, 10'd600};
                end
                default:
                    // anything, inverted ranges included
                    for (int k = 0; k < NUM_CLASSES; k++)
                    begin
                        lo[k] = CFG_BITS'($urandom_range(0, (1 << CFG_BITS) - 1));
                        hi[k] = CFG_BITS'($urandom_range(0, (1 << CFG_BITS) - 1));
                    end
            endcase
            load_thresholds(lo, hi);
            @(negedge clk);

            if (ph < 2)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 77;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            burst_n = 0;
            if (ph == 1 || ph == 4)
                plan_fill_burst(burst_n);
            plan_traffic(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            failures += pending_results.size();
        end
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
